### sv/eacfp_pkg.sv
// Package for the escaped address/color frame parser.
// Holds framing byte codes, register indexes, the config struct and the unescape table.
// No dependencies.
package eacfp_pkg;

	// Framing byte codes on the serial bus
	localparam logic [7:0] START_BYTE  = 8'h42;
	localparam logic [7:0] ABORT_BYTE  = 8'h23;
	localparam logic [7:0] ESCAPE_BYTE = 8'h65;
	localparam logic [7:0] ALT_BYTE    = 8'h66;

	// Escape codes that map back to the special bytes
	localparam logic [7:0] ESC_ABORT  = 8'h01;
	localparam logic [7:0] ESC_START  = 8'h02;
	localparam logic [7:0] ESC_ESCAPE = 8'h03;
	localparam logic [7:0] ESC_ALT    = 8'h04;

	// Frame positions: address byte, red, green, blue, white, then idle
	localparam logic [2:0] POS_ADDR  = 3'd0;
	localparam logic [2:0] POS_RED   = 3'd1;
	localparam logic [2:0] POS_GREEN = 3'd2;
	localparam logic [2:0] POS_BLUE  = 3'd3;
	localparam logic [2:0] POS_WHITE = 3'd4;
	localparam logic [2:0] POS_IDLE  = 3'd5;

	// Register indexes (byte address = 4 * index)
	typedef enum logic {
		REG_OWN_ADDR   = 1'b0,
		REG_BCAST_ADDR = 1'b1
	} reg_idx_t;

	// Configuration seen by the parser
	typedef struct packed {
		logic [7:0] own_address;
		logic [7:0] broadcast_address;
	} cfg_t;

	// Map an escaped byte back to its original value
	function automatic logic [7:0] unescape(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			ESC_ABORT:  r = ABORT_BYTE;
			ESC_START:  r = START_BYTE;
			ESC_ESCAPE: r = ESCAPE_BYTE;
			ESC_ALT:    r = ALT_BYTE;
			default:    r = b;
		endcase
		return r;
	endfunction

endpackage

### sv/eacfp_regs.sv
// APB-style configuration registers for the frame parser: own and broadcast address.
// Depends on eacfp_pkg.
module eacfp_regs
	import eacfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite;

	// Register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_OWN_ADDR:   cfg_q.own_address       <= pwdata[7:0];
				REG_BCAST_ADDR: cfg_q.broadcast_address <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_OWN_ADDR:   prdata = {24'd0, cfg_q.own_address};
			REG_BCAST_ADDR: prdata = {24'd0, cfg_q.broadcast_address};
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### sv/escaped_address_color_frame_parser.sv
// Escaped address/color frame parser: takes one serial byte per word, emits a color word
// at the end of each matched frame, with color valid set in the cycle after byte accept.
// Throughput: one byte per cycle while the color output is free or being taken; the
// frame state and the color output register are updated in the cycle the byte is accepted.
// Reset: async active low; position, escape and match clear, channel holds reset to 1,
// addresses reset to 0. Depends on eacfp_pkg and eacfp_regs.
module escaped_address_color_frame_parser
	import eacfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  rx_byte,
	// color output
	output logic        color_valid,
	input  logic        color_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  white,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg;

	eacfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Frame state
	logic [2:0] pos_q;
	logic       esc_q;
	logic       match_q;
	logic [7:0] red_q, green_q, blue_q;

	// Output register
	logic       out_valid_s1;
	logic [7:0] red_s1, green_s1, blue_s1, white_s1;

	// Next-state logic
	logic       accept;
	logic [7:0] data;
	logic       ordinary;
	logic       active;
	logic       emit;
	logic [2:0] pos_d;
	logic       esc_d, match_d;
	logic [7:0] red_d, green_d, blue_d;

	assign byte_ready = ~out_valid_s1 | color_ready;
	assign accept     = byte_valid & byte_ready;

	assign data     = esc_q ? unescape(rx_byte) : rx_byte;
	assign ordinary = (rx_byte != START_BYTE) && (rx_byte != ABORT_BYTE)
	                  && (rx_byte != ESCAPE_BYTE);
	assign active   = pos_q < POS_IDLE;
	assign emit     = ordinary & match_q & (pos_q == POS_WHITE);

	// Parse one byte
	always_comb begin
		pos_d   = pos_q;
		esc_d   = esc_q;
		match_d = match_q;
		red_d   = red_q;
		green_d = green_q;
		blue_d  = blue_q;
		if (rx_byte == START_BYTE) begin
			pos_d   = POS_ADDR;
			esc_d   = 1'b0;
			match_d = 1'b0;
		end else if (rx_byte == ABORT_BYTE) begin
			pos_d = POS_IDLE;
		end else if (rx_byte == ESCAPE_BYTE) begin
			esc_d = 1'b1;
		end else begin
			esc_d = 1'b0;
			if (pos_q == POS_ADDR) begin
				match_d = (data == cfg.own_address) || (data == cfg.broadcast_address);
			end else if (match_q && active) begin
				case (pos_q)
					POS_RED:   red_d   = data;
					POS_GREEN: green_d = data;
					POS_BLUE:  blue_d  = data;
					default:   match_d = 1'b0;
				endcase
			end
			if (active) begin
				pos_d = pos_q + 3'd1;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_ADDR;
			esc_q   <= 1'b0;
			match_q <= 1'b0;
			red_q   <= 8'd1;
			green_q <= 8'd1;
			blue_q  <= 8'd1;
		end else if (accept) begin
			pos_q   <= pos_d;
			esc_q   <= esc_d;
			match_q <= match_d;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= emit;
		end else if (color_ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			red_s1   <= red_q;
			green_s1 <= green_q;
			blue_s1  <= blue_q;
			white_s1 <= data;
		end
	end

	assign color_valid = out_valid_s1;
	assign red         = red_s1;
	assign green       = green_s1;
	assign blue        = blue_s1;
	assign white       = white_s1;

endmodule
